>>> rtl/core/dns_pkg.sv
package dns_pkg;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_SAT   = 2'd1,
        ST_ZERO  = 2'd2
    } status_t;

    typedef struct packed {
        logic zero_sum;
        logic zero_dot;
        logic neg;
    } ctl_t;

    localparam int DIR_WIDTH   = 16;
    localparam int SQRT_SHIFT  = 60;
    localparam int QUOT_WIDTH  = 32;
    localparam int CTL_WIDTH   = $bits(ctl_t);

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage

>>> rtl/core/dns_front.sv
module dns_front #(
    parameter int CW = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  en,
    input  logic signed [CW-1:0]  inner_x,
    input  logic signed [CW-1:0]  inner_y,
    input  logic signed [CW-1:0]  inner_z,
    input  logic signed [CW-1:0]  outer_x,
    input  logic signed [CW-1:0]  outer_y,
    input  logic signed [CW-1:0]  outer_z,
    input  logic signed [15:0]    dir_x,
    input  logic signed [15:0]    dir_y,
    input  logic signed [15:0]    dir_z,
    output logic                  valid,
    output logic [2*CW+1:0]       sum_sq,
    output logic [CW+16:0]        adot,
    output dns_pkg::ctl_t         ctl
);
    import dns_pkg::*;

    localparam int DW   = CW + 1;
    localparam int SW   = 2 * CW + 2;
    localparam int PW   = DW + DIR_WIDTH;
    localparam int DOTW = CW + 18;
    localparam int AW   = CW + 17;

    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [DW-1:0]    d_reg [3];
    logic signed [15:0]      n_reg [3];
    logic [2*CW-1:0]         sq_reg [3];
    logic signed [PW-1:0]    pr_reg [3];
    logic [SW-1:0]           sum_reg;
    logic [AW-1:0]           adot_reg;
    ctl_t                    ctl_reg;

    logic signed [2*DW-1:0]  sq_full [3];
    logic signed [PW-1:0]    pr_full [3];
    logic [SW-1:0]           sum_next;
    logic signed [DOTW-1:0]  dot_next;
    logic signed [DOTW-1:0]  dot_neg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_full[i] = d_reg[i] * d_reg[i];
            pr_full[i] = d_reg[i] * n_reg[i];
        end
        sum_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        dot_next = DOTW'(pr_reg[0]) + DOTW'(pr_reg[1]) + DOTW'(pr_reg[2]);
        dot_neg  = -dot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= DW'(outer_x) - DW'(inner_x);
            d_reg[1] <= DW'(outer_y) - DW'(inner_y);
            d_reg[2] <= DW'(outer_z) - DW'(inner_z);
            n_reg[0] <= dir_x;
            n_reg[1] <= dir_y;
            n_reg[2] <= dir_z;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= sq_full[i][2*CW-1:0];
                pr_reg[i] <= pr_full[i];
            end
            sum_reg          <= sum_next;
            ctl_reg.zero_sum <= (sum_next == '0);
            ctl_reg.zero_dot <= (dot_next == '0);
            ctl_reg.neg      <= dot_next[DOTW-1];
            adot_reg         <= dot_next[DOTW-1] ? dot_neg[AW-1:0] : dot_next[AW-1:0];
        end
    end

    assign valid  = s3_valid_reg;
    assign sum_sq = sum_reg;
    assign adot   = adot_reg;
    assign ctl    = ctl_reg;

endmodule

>>> rtl/core/dns_queue.sv
module dns_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             pop,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'd2);
    assign pop      = (count_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count did not advance on push");

endmodule

>>> rtl/core/dns_sqrt.sv
module dns_sqrt #(
    parameter int CW = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2*CW+1:0]     in_sum,
    input  logic [CW+16:0]      in_adot,
    input  dns_pkg::ctl_t       in_ctl,
    output logic                out_valid,
    output logic [CW+30:0]      out_root,
    output logic [CW+16:0]      out_adot,
    output dns_pkg::ctl_t       out_ctl
);
    import dns_pkg::*;

    localparam int SW = 2 * CW + 2;
    localparam int TW = SW + SQRT_SHIFT;
    localparam int RW = TW / 2;
    localparam int AW = CW + 17;

    logic            vld_reg  [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [TW-1:0]   t_reg    [RW];
    logic [AW-1:0]   adot_reg [RW];
    ctl_t            ctl_reg  [RW];

    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        logic          src_vld;
        logic [RW+1:0] src_rem;
        logic [RW-1:0] src_root;
        logic [TW-1:0] src_t;
        logic [AW-1:0] src_adot;
        ctl_t          src_ctl;
        logic [RW+1:0] shifted;
        logic [RW+1:0] trial;
        logic          take;

        if (s == 0)
        begin : g_first
            assign src_vld  = in_valid;
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_t    = {in_sum, {SQRT_SHIFT{1'b0}}};
            assign src_adot = in_adot;
            assign src_ctl  = in_ctl;
        end
        else
        begin : g_next
            assign src_vld  = vld_reg[s-1];
            assign src_rem  = rem_reg[s-1];
            assign src_root = root_reg[s-1];
            assign src_t    = t_reg[s-1];
            assign src_adot = adot_reg[s-1];
            assign src_ctl  = ctl_reg[s-1];
        end

        assign shifted = {src_rem[RW-1:0], src_t[TW-1:TW-2]};
        assign trial   = {src_root, 2'b01};
        assign take    = (shifted >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= take ? shifted - trial : shifted;
            root_reg[s] <= {src_root[RW-2:0], take};
            t_reg[s]    <= {src_t[TW-3:0], 2'b00};
            adot_reg[s] <= src_adot;
            ctl_reg[s]  <= src_ctl;
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_adot  = adot_reg[RW-1];
    assign out_ctl   = ctl_reg[RW-1];

endmodule

>>> rtl/core/dns_div.sv
module dns_div #(
    parameter int CW = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [CW+30:0]      in_root,
    input  logic [CW+16:0]      in_adot,
    input  dns_pkg::ctl_t       in_ctl,
    output logic                done,
    output logic signed [31:0]  secant,
    output logic [1:0]          status
);
    import dns_pkg::*;

    localparam int RW = CW + 31;
    localparam int AW = CW + 17;
    localparam int XW = AW + QUOT_WIDTH + 1;

    logic                  vld_reg  [QUOT_WIDTH];
    logic [RW-1:0]         rem_reg  [QUOT_WIDTH];
    logic [QUOT_WIDTH-1:0] q_reg    [QUOT_WIDTH];
    logic [AW-1:0]         adot_reg [QUOT_WIDTH];
    ctl_t                  ctl_reg  [QUOT_WIDTH];
    logic                  ovf_reg  [QUOT_WIDTH];

    logic                  done_reg;
    logic [31:0]           secant_reg;
    status_t               status_reg;
    logic [31:0]           secant_next;
    status_t               status_next;

    for (genvar s = 0; s < QUOT_WIDTH; s++)
    begin : g_stage
        logic                  src_vld;
        logic [RW-1:0]         src_rem;
        logic [QUOT_WIDTH-1:0] src_q;
        logic [AW-1:0]         src_adot;
        ctl_t                  src_ctl;
        logic                  src_ovf;
        logic [XW-1:0]         rem_x;
        logic [XW-1:0]         div_x;
        logic [XW-1:0]         diff;
        logic                  take;

        if (s == 0)
        begin : g_first
            assign src_vld  = in_valid;
            assign src_rem  = in_root;
            assign src_q    = '0;
            assign src_adot = in_adot;
            assign src_ctl  = in_ctl;
            assign src_ovf  = (XW'(in_root) >= {1'b0, in_adot, {QUOT_WIDTH{1'b0}}});
        end
        else
        begin : g_next
            assign src_vld  = vld_reg[s-1];
            assign src_rem  = rem_reg[s-1];
            assign src_q    = q_reg[s-1];
            assign src_adot = adot_reg[s-1];
            assign src_ctl  = ctl_reg[s-1];
            assign src_ovf  = ovf_reg[s-1];
        end

        assign rem_x = XW'(src_rem);
        assign div_x = XW'(src_adot) << (QUOT_WIDTH - 1 - s);
        assign take  = (rem_x >= div_x);
        assign diff  = rem_x - div_x;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= take ? diff[RW-1:0] : src_rem;
            q_reg[s]    <= {src_q[QUOT_WIDTH-2:0], take};
            adot_reg[s] <= src_adot;
            ctl_reg[s]  <= src_ctl;
            ovf_reg[s]  <= src_ovf;
        end
    end

    always_comb
    begin
        logic [QUOT_WIDTH-1:0] q;
        ctl_t                  c;
        q = q_reg[QUOT_WIDTH-1];
        c = ctl_reg[QUOT_WIDTH-1];
        priority if (c.zero_sum)
        begin
            secant_next = '0;
            status_next = ST_ZERO;
        end
        else if (c.zero_dot)
        begin
            secant_next = SAT_POS;
            status_next = ST_SAT;
        end
        else if (!c.neg)
        begin
            if (ovf_reg[QUOT_WIDTH-1] || q > SAT_POS)
            begin
                secant_next = SAT_POS;
                status_next = ST_SAT;
            end
            else
            begin
                secant_next = q;
                status_next = ST_VALID;
            end
        end
        else
        begin
            if (ovf_reg[QUOT_WIDTH-1] || q > SAT_NEG)
            begin
                secant_next = SAT_NEG;
                status_next = ST_SAT;
            end
            else
            begin
                secant_next = -q;
                status_next = ST_VALID;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[QUOT_WIDTH-1];
    end

    always_ff @(posedge clk)
    begin
        secant_reg <= secant_next;
        status_reg <= status_next;
    end

    assign done   = done_reg;
    assign secant = secant_reg;
    assign status = status_reg;

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_ZERO) |-> (secant_reg == '0))
        else $error("zero displacement item with nonzero secant");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QUOT_WIDTH-1] |=> done_reg)
        else $error("finished item lost at output");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_SAT) |->
            (secant_reg == SAT_POS || secant_reg == SAT_NEG))
        else $error("saturated item with unsaturated value");

endmodule

>>> rtl/core/displacement_normal_secant_unit.sv
// Displacement normal secant unit.
// An item is taken at a rising edge where start is high and busy is low. It carries
// an inner point, an outer point (signed Q12.12, COORD_WIDTH bits) and a normal
// (signed Q2.14). The unit returns |outer - inner| / ((outer - inner) . normal)
// as signed Q16.16 on secant, with status 0 valid, 1 saturated or zero dot
// product, 2 zero displacement.
// Each result appears for one cycle with done high; the receiver cannot stall it.
// Three front stages form the differences, squares and dot product, items then
// pass through the two-entry queue, the square root takes COORD_WIDTH + 31 stages
// of one bit each, the division takes 32 stages of one quotient bit each, and one
// output register follows.
// Throughput is one item per cycle; every back stage is pipelined, so the queue
// never fills and busy stays low in operation.
// Reset clears all valid bits and the queue; items in flight are dropped.
module displacement_normal_secant_unit #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] inner_x,
    input  logic signed [COORD_WIDTH-1:0] inner_y,
    input  logic signed [COORD_WIDTH-1:0] inner_z,
    input  logic signed [COORD_WIDTH-1:0] outer_x,
    input  logic signed [COORD_WIDTH-1:0] outer_y,
    input  logic signed [COORD_WIDTH-1:0] outer_z,
    input  logic signed [15:0]            dir_x,
    input  logic signed [15:0]            dir_y,
    input  logic signed [15:0]            dir_z,
    output logic                          done,
    output logic signed [31:0]            secant,
    output logic [1:0]                    status
);
    import dns_pkg::*;

    localparam int SW = 2 * COORD_WIDTH + 2;
    localparam int AW = COORD_WIDTH + 17;
    localparam int RW = COORD_WIDTH + 31;
    localparam int QW = CTL_WIDTH + SW + AW;

    logic          q_full;
    logic          accept;
    logic          f_valid;
    logic [SW-1:0] f_sum;
    logic [AW-1:0] f_adot;
    ctl_t          f_ctl;
    logic          push;
    logic          pop;
    logic [QW-1:0] pop_data;
    logic          r_valid;
    logic [RW-1:0] r_root;
    logic [AW-1:0] r_adot;
    ctl_t          r_ctl;

    assign busy   = q_full;
    assign accept = start && !busy;
    assign push   = f_valid && !q_full;

    dns_front #(.CW(COORD_WIDTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .en      (!q_full),
        .inner_x (inner_x),
        .inner_y (inner_y),
        .inner_z (inner_z),
        .outer_x (outer_x),
        .outer_y (outer_y),
        .outer_z (outer_z),
        .dir_x   (dir_x),
        .dir_y   (dir_y),
        .dir_z   (dir_z),
        .valid   (f_valid),
        .sum_sq  (f_sum),
        .adot    (f_adot),
        .ctl     (f_ctl)
    );

    dns_queue #(.WIDTH(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_ctl, f_sum, f_adot}),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data)
    );

    dns_sqrt #(.CW(COORD_WIDTH)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pop),
        .in_sum    (pop_data[AW+SW-1:AW]),
        .in_adot   (pop_data[AW-1:0]),
        .in_ctl    (ctl_t'(pop_data[QW-1:AW+SW])),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_adot  (r_adot),
        .out_ctl   (r_ctl)
    );

    dns_div #(.CW(COORD_WIDTH)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (r_valid),
        .in_root  (r_root),
        .in_adot  (r_adot),
        .in_ctl   (r_ctl),
        .done     (done),
        .secant   (secant),
        .status   (status)
    );

endmodule

>>> tb/tb_displacement_normal_secant_unit.sv
`timescale 1ns / 100ps

module tb_displacement_normal_secant_unit;
    import dns_pkg::*;

    localparam int COORD_WIDTH = 24;
    localparam int CLK_HALF = 1;
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] ix;
        logic signed [COORD_WIDTH-1:0] iy;
        logic signed [COORD_WIDTH-1:0] iz;
        logic signed [COORD_WIDTH-1:0] ox;
        logic signed [COORD_WIDTH-1:0] oy;
        logic signed [COORD_WIDTH-1:0] oz;
        logic signed [15:0]            nx;
        logic signed [15:0]            ny;
        logic signed [15:0]            nz;
    } vertex_t;

    typedef struct {
        logic [31:0] secant;
        status_t     status;
    } secant_res_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [COORD_WIDTH-1:0] inner_x;
    logic signed [COORD_WIDTH-1:0] inner_y;
    logic signed [COORD_WIDTH-1:0] inner_z;
    logic signed [COORD_WIDTH-1:0] outer_x;
    logic signed [COORD_WIDTH-1:0] outer_y;
    logic signed [COORD_WIDTH-1:0] outer_z;
    logic signed [15:0]            dir_x;
    logic signed [15:0]            dir_y;
    logic signed [15:0]            dir_z;
    logic                          done;
    logic signed [31:0]            secant;
    logic [1:0]                    status;

    secant_res_t pending_secants[$];
    int          accepted_items;
    int          checked_results;
    int          mismatches;
    int          idle_cycles;
    int          n_zero_disp;
    int          n_saturated;
    int          n_valid;

    displacement_normal_secant_unit #(
        .COORD_WIDTH(COORD_WIDTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .inner_x(inner_x),
        .inner_y(inner_y),
        .inner_z(inner_z),
        .outer_x(outer_x),
        .outer_y(outer_y),
        .outer_z(outer_z),
        .dir_x(dir_x),
        .dir_y(dir_y),
        .dir_z(dir_z),
        .done(done),
        .secant(secant),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic secant_res_t predict_secant(vertex_t v);
        longint        dx;
        longint        dy;
        longint        dz;
        longint        dot;
        logic [159:0]  sum_sq;
        logic [159:0]  target;
        logic [159:0]  prod;
        logic [159:0]  adot;
        logic [31:0]   q;
        logic [31:0]   cand;
        secant_res_t   r;
        dx = longint'(v.ox) - longint'(v.ix);
        dy = longint'(v.oy) - longint'(v.iy);
        dz = longint'(v.oz) - longint'(v.iz);
        dot = dx * longint'(v.nx) + dy * longint'(v.ny) + dz * longint'(v.nz);
        sum_sq = 160'(dx * dx) + 160'(dy * dy) + 160'(dz * dz);
        if (sum_sq == 0)
        begin
            r.secant = 32'd0;
            r.status = ST_ZERO;
            return r;
        end
        if (dot == 0)
        begin
            r.secant = SAT_POS;
            r.status = ST_SAT;
            return r;
        end
        adot = (dot < 0) ? 160'(-dot) : 160'(dot);
        target = sum_sq << SQRT_SHIFT;
        q = 32'd0;
        for (int b = QUOT_WIDTH - 1; b >= 0; b--)
        begin
            cand = q | (32'd1 << b);
            prod = 160'(cand) * adot;
            if (prod * prod <= target)
                q = cand;
        end
        if (dot > 0)
        begin
            if (q > 32'h7FFF_FFFF)
            begin
                r.secant = SAT_POS;
                r.status = ST_SAT;
            end
            else
            begin
                r.secant = q;
                r.status = ST_VALID;
            end
        end
        else
        begin
            if (q > 32'h8000_0000)
            begin
                r.secant = SAT_NEG;
                r.status = ST_SAT;
            end
            else
            begin
                r.secant = -q;
                r.status = ST_VALID;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        vertex_t     v;
        secant_res_t exp_res;
        if (rst_n && start && !busy)
        begin
            v.ix = inner_x;
            v.iy = inner_y;
            v.iz = inner_z;
            v.ox = outer_x;
            v.oy = outer_y;
            v.oz = outer_z;
            v.nx = dir_x;
            v.ny = dir_y;
            v.nz = dir_z;
            pending_secants.push_back(predict_secant(v));
            accepted_items++;
        end
        if (rst_n && done)
        begin
            checked_results++;
            if (pending_secants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: secant=%h status=%0d", secant, status);
            end
            else
            begin
                exp_res = pending_secants.pop_front();
                case (exp_res.status)
                    ST_ZERO: n_zero_disp++;
                    ST_SAT:  n_saturated++;
                    default: n_valid++;
                endcase
                if (secant !== exp_res.secant || status !== exp_res.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected secant=%h status=%0d, got secant=%h status=%0d",
                                 exp_res.secant, exp_res.status, secant, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding", pending_secants.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_vertex(vertex_t v);
        int seen;
        inner_x = v.ix;
        inner_y = v.iy;
        inner_z = v.iz;
        outer_x = v.ox;
        outer_y = v.oy;
        outer_z = v.oz;
        dir_x = v.nx;
        dir_y = v.ny;
        dir_z = v.nz;
        start = 1'b1;
        seen = accepted_items;
        do
            @(negedge clk);
        while (accepted_items == seen);
    endtask

    task automatic pause_sender(int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    function automatic vertex_t make_vertex(longint ix, longint iy, longint iz,
                                            longint ox, longint oy, longint oz,
                                            int nx, int ny, int nz);
        vertex_t v;
        v.ix = COORD_WIDTH'(ix);
        v.iy = COORD_WIDTH'(iy);
        v.iz = COORD_WIDTH'(iz);
        v.ox = COORD_WIDTH'(ox);
        v.oy = COORD_WIDTH'(oy);
        v.oz = COORD_WIDTH'(oz);
        v.nx = 16'(nx);
        v.ny = 16'(ny);
        v.nz = 16'(nz);
        return v;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
        return COORD_WIDTH'($urandom);
    endfunction

    task automatic test_special_cases();
        send_vertex(make_vertex(100, -200, 300, 100, -200, 300, 16384, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 4096, 0, 0, 0, 16384, 0));
        send_vertex(make_vertex(0, 0, 0, 1, 4000000, 0, 1, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 1, 4000000, 0, -1, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 2, 0, 0, -1, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 1000, 1732, 0, -1, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 1000, 1733, 0, -1, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 1000, 1732, 0, 1, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 4096, 0, 0, 16384, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 0, 0, -4096, 0, 0, -16384));
        pause_sender(3);
    endtask

    task automatic test_extremes();
        send_vertex(make_vertex(8388607, 8388607, 8388607,
                                -8388608, -8388608, -8388608, 16384, 16384, 16384));
        send_vertex(make_vertex(-8388608, -8388608, -8388608,
                                8388607, 8388607, 8388607, -16384, -16384, -16384));
        send_vertex(make_vertex(-8388608, 8388607, -8388608,
                                8388607, -8388608, 8388607, 32767, -32768, 32767));
        send_vertex(make_vertex(8388607, -8388608, 0,
                                -8388608, 8388607, 0, -32768, 32767, -1));
        send_vertex(make_vertex(0, 0, -8388608, 0, 0, 8388607, 0, 0, 1));
        send_vertex(make_vertex(-1, -1, -1, 0, 0, 0, -32768, -32768, -32768));
        send_vertex(make_vertex(8388607, 0, 0, -8388608, 0, 1, 32767, 0, 0));
        send_vertex(make_vertex(5592405, -5592406, 2796202,
                                -5592406, 5592405, -2796203, 21845, -21846, 10922));
        pause_sender(2);
    endtask

    task automatic test_random_bursts();
        vertex_t v;
        int      burst;
        int      kind;
        int      sent;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++)
            begin
                kind = $urandom_range(0, 9);
                v.ix = rand_coord();
                v.iy = rand_coord();
                v.iz = rand_coord();
                v.nx = 16'($urandom);
                v.ny = 16'($urandom);
                v.nz = 16'($urandom);
                if (kind < 4)
                begin
                    v.ox = COORD_WIDTH'(v.ix
                           + $signed(COORD_WIDTH'($urandom_range(0, 8191))) - 4096);
                    v.oy = COORD_WIDTH'(v.iy
                           + $signed(COORD_WIDTH'($urandom_range(0, 8191))) - 4096);
                    v.oz = COORD_WIDTH'(v.iz
                           + $signed(COORD_WIDTH'($urandom_range(0, 8191))) - 4096);
                    v.nx = 16'($urandom_range(0, 32768) - 16384);
                    v.ny = 16'($urandom_range(0, 32768) - 16384);
                    v.nz = 16'($urandom_range(0, 32768) - 16384);
                end
                else if (kind < 6)
                begin
                    v.ox = COORD_WIDTH'(v.ix
                           + $signed(COORD_WIDTH'($urandom_range(0, 63))) - 32);
                    v.oy = v.iy;
                    v.oz = COORD_WIDTH'(v.iz
                           + $signed(COORD_WIDTH'($urandom_range(0, 3))) - 1);
                    v.nx = 16'($urandom_range(0, 2) - 1);
                    v.ny = 16'($urandom_range(0, 8) - 4);
                    v.nz = 16'($urandom_range(0, 2) - 1);
                end
                else if (kind == 6)
                begin
                    v.ox = v.ix;
                    v.oy = v.iy;
                    v.oz = v.iz;
                end
                else
                begin
                    v.ox = rand_coord();
                    v.oy = rand_coord();
                    v.oz = rand_coord();
                end
                send_vertex(v);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
        start = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        inner_x = '0;
        inner_y = '0;
        inner_z = '0;
        outer_x = '0;
        outer_y = '0;
        outer_z = '0;
        dir_x = '0;
        dir_y = '0;
        dir_z = '0;
        accepted_items = 0;
        checked_results = 0;
        mismatches = 0;
        n_zero_disp = 0;
        n_saturated = 0;
        n_valid = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_special_cases();
        test_extremes();
        test_random_bursts();

        while (pending_secants.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d vertices and checked %0d secants.", accepted_items, checked_results);
        $display("Results: %0d valid, %0d saturated, %0d zero displacement.",
                 n_valid, n_saturated, n_zero_disp);
        if (mismatches == 0 && pending_secants.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> displacement_normal_secant_unit.f
rtl/core/dns_pkg.sv
rtl/core/dns_front.sv
rtl/core/dns_queue.sv
rtl/core/dns_sqrt.sv
rtl/core/dns_div.sv
rtl/core/displacement_normal_secant_unit.sv
tb/tb_displacement_normal_secant_unit.sv
